// ===== rtl/mrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Shared types and helpers for the mesh route table: request and response
// payloads, the stored route entry and call sign canonicalisation.
// ----------------------------------------------------------------------------
package mrt_pkg;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_LEARN  = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CHECK  = 2'd3
  } func_e;

  // request payload
  typedef struct packed {
    func_e       func;
    logic [63:0] dest_call;
    logic [63:0] via_call;
    logic [7:0]  hop_count;
    logic        via_available;
    logic [31:0] now_time;
  } req_t;

  // response payload
  typedef struct packed {
    logic        found;
    logic [63:0] via_out;
    logic [7:0]  hops_out;
    logic        table_changed;
    logic        new_destination;
    logic        evicted;
  } rsp_t;

  // one stored route
  typedef struct packed {
    logic        valid;
    logic [63:0] dest;
    logic [63:0] via;
    logic [7:0]  hops;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  // commands from controller to datapath
  typedef struct packed {
    logic start;
    logic rd_en;
    logic clr_we;
    logic commit;
  } cmd_t;

  // cut a call at its first zero byte and to its low chars bytes
  function automatic logic [63:0] canon_call(logic [63:0] x, int unsigned chars);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= chars || x[8*i +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*i +: 8] = x[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/mrt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface mrt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mrt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table controller
// Sequences the clearing pass, the table scan and the commit of each
// operation, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module mrt_ctrl #(
  parameter int unsigned TABLE_DEPTH = 32,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output mrt_pkg::cmd_t      cmd_o,
  output logic [AW-1:0]      addr_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic          cnt_last;

  assign cnt_last = (cnt_q == AW'(TABLE_DEPTH - 1));

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_FINISH: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        // wait for the output register to be free
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign addr_o = cnt_q;

  // response valid: set on commit, cleared on transfer
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

// ===== rtl/mrt_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table datapath
// Holds the own call register, the route memory, the scan accumulators and
// the response register; decides and performs each operation's update.
// ----------------------------------------------------------------------------
module mrt_dpath #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned CALL_CHARS  = 8,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,
  input  mrt_pkg::req_t req_i,
  input  mrt_pkg::cmd_t cmd_i,
  input  logic [AW-1:0] addr_i,
  output mrt_pkg::rsp_t rsp_o
);

  // own call register
  logic [63:0] own_call_q;

  // captured operation
  mrt_pkg::func_e func_q;
  logic [63:0]    dest_q, via_q, me_q;
  logic [7:0]     hops_q;
  logic           avail_q;
  logic [31:0]    now_q;

  // read pipeline
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic [mrt_pkg::EntryWidth-1:0] ram_rdata;
  mrt_pkg::entry_t rd_entry;

  // scan accumulators
  logic          hit_q;
  logic [AW-1:0] hit_idx_q;
  logic [63:0]   hit_via_q;
  logic [7:0]    hit_hops_q;
  logic          free_q;
  logic [AW-1:0] free_idx_q;
  logic [AW-1:0] min_idx_q;
  logic [31:0]   min_time_q;

  // commit decision
  mrt_pkg::rsp_t   rsp_c;
  mrt_pkg::rsp_t   rsp_q;
  mrt_pkg::entry_t wr_entry_c;
  logic            wr_en_c;
  logic [AW-1:0]   wr_idx_c;
  logic            learn_ok;
  logic            dest_nz;

  // memory ports
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  mrt_pkg::entry_t                ram_wentry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_call_q <= '0;
    end else if (cfg_we_i) begin
      own_call_q <= cfg_wdata_i;
    end
  end

  // capture the request in canonical form
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q  <= req_i.func;
      dest_q  <= mrt_pkg::canon_call(req_i.dest_call, CALL_CHARS);
      via_q   <= mrt_pkg::canon_call(req_i.via_call, CALL_CHARS);
      me_q    <= mrt_pkg::canon_call(own_call_q, CALL_CHARS);
      hops_q  <= req_i.hop_count;
      avail_q <= req_i.via_available;
      now_q   <= req_i.now_time;
    end
  end

  // track which slot the read data belongs to
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_idx_q <= addr_i;
    end
  end

  assign rd_entry = mrt_pkg::entry_t'(ram_rdata);

  // scan: first matching destination, first free slot, oldest slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (!hit_q && rd_entry.valid && rd_entry.dest == dest_q) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= rd_idx_q;
        hit_via_q  <= rd_entry.via;
        hit_hops_q <= rd_entry.hops;
      end
      if (!free_q && !rd_entry.valid) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (rd_idx_q == '0 || rd_entry.stamp < min_time_q) begin
        min_idx_q  <= rd_idx_q;
        min_time_q <= rd_entry.stamp;
      end
    end
  end

  assign dest_nz  = (dest_q != '0);
  assign learn_ok = dest_nz && (via_q != '0) && (dest_q != me_q) &&
                    !(via_q == dest_q && hops_q != '0) && (via_q != me_q) && avail_q;

  // decide the result and the table update
  always_comb begin
    rsp_c      = '0;
    wr_en_c    = 1'b0;
    wr_idx_c   = hit_idx_q;
    wr_entry_c = '{valid: 1'b1, dest: dest_q, via: via_q, hops: hops_q, stamp: now_q};
    case (func_q)
      mrt_pkg::FUNC_LOOKUP: begin
        if (dest_nz && hit_q) begin
          rsp_c.found    = 1'b1;
          rsp_c.via_out  = hit_via_q;
          rsp_c.hops_out = hit_hops_q;
        end
      end
      mrt_pkg::FUNC_LEARN: begin
        if (learn_ok) begin
          if (!hit_q) begin
            wr_en_c               = 1'b1;
            wr_idx_c              = free_q ? free_idx_q : min_idx_q;
            rsp_c.table_changed   = 1'b1;
            rsp_c.new_destination = 1'b1;
            rsp_c.evicted         = !free_q;
          end else if (hops_q < hit_hops_q) begin
            wr_en_c             = 1'b1;
            rsp_c.table_changed = 1'b1;
          end else if (hit_via_q == via_q) begin
            // same via: refresh the time stamp only
            wr_en_c         = 1'b1;
            wr_entry_c.via  = hit_via_q;
            wr_entry_c.hops = hit_hops_q;
          end
        end
      end
      mrt_pkg::FUNC_REMOVE: begin
        if (dest_nz && hit_q && hit_via_q == dest_q) begin
          wr_en_c             = 1'b1;
          wr_entry_c.valid    = 1'b0;
          rsp_c.found         = 1'b1;
          rsp_c.table_changed = 1'b1;
        end
      end
      mrt_pkg::FUNC_CHECK: begin
        rsp_c.found = dest_nz && hit_q && (hit_via_q == via_q);
      end
      default: begin
        rsp_c = '0;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_c;
    end
  end

  assign rsp_o = rsp_q;

  // memory write: clearing pass or commit
  always_comb begin
    ram_we     = cmd_i.clr_we || (cmd_i.commit && wr_en_c);
    ram_waddr  = cmd_i.clr_we ? addr_i : wr_idx_c;
    ram_wentry = cmd_i.clr_we ? mrt_pkg::entry_t'('0) : wr_entry_c;
  end

  mrt_ram #(
    .WIDTH (mrt_pkg::EntryWidth),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_i),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== rtl/mesh_route_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh route table
// Bounded distance-vector route table with oldest-entry eviction, keyed by
// packed destination call sign.
// ----------------------------------------------------------------------------
// Each operation (lookup, learn, remove direct, check pair) is a scan, a
// finish and a commit between the request transfer and the response being
// offered: the route memory has one read port, so every slot is read once in
// turn, then the finish state settles the last read and the commit state
// performs the update and loads the response register. The controller then
// returns to idle, so a request is taken only after the previous one has
// committed. A new request is taken while an earlier response still waits;
// its commit is held until that response has been taken. After reset a
// clearing pass marks every slot empty; no request is taken until it ends,
// while writes to own_call are taken at any time. Call signs are cut at the
// first zero byte and to CALL_CHARS bytes before use.
// ----------------------------------------------------------------------------
module mesh_route_table #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned CALL_CHARS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  mrt_stream_if.sink   req_i,
  mrt_stream_if.source rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  mrt_pkg::cmd_t cmd;
  logic [AW-1:0] addr;
  mrt_pkg::rsp_t rsp_data;

  // sequencing and handshakes
  mrt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  // table storage and decisions
  mrt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CALL_CHARS  (CALL_CHARS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i.data),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .rsp_o       (rsp_data)
  );

  assign rsp_o.data = rsp_data;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh route table testbench
// Drives lookup, learn, remove-direct and check-pair requests into the route
// table over valid/ready channels with random gaps on both sides. A local
// model of the table predicts every response at request transfer, and each
// response transfer is compared field by field with the oldest prediction.
// own_call is rewritten between phases while the table is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned CALL_CHARS   = 8;
  localparam int unsigned OP_LATENCY   = TABLE_DEPTH + 3;
  localparam int unsigned POOL_SIZE    = 48;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned IDLE_PERCENT = 23;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;

  mrt_stream_if #(.T(mrt_pkg::req_t)) req_if ();
  mrt_stream_if #(.T(mrt_pkg::rsp_t)) rsp_if ();

  mesh_route_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CALL_CHARS (CALL_CHARS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // model of the route table and own call
  bit          route_valid [TABLE_DEPTH];
  logic [63:0] route_dest  [TABLE_DEPTH];
  logic [63:0] route_via   [TABLE_DEPTH];
  logic [7:0]  route_hops  [TABLE_DEPTH];
  logic [31:0] route_stamp [TABLE_DEPTH];
  logic [63:0] node_call = '0;

  mrt_pkg::rsp_t expected_rsp_q[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            req_idle_en = 1'b1;
  bit            rsp_idle_en = 1'b1;
  logic [63:0]   call_pool [POOL_SIZE];
  logic [31:0]   stamp_now = '0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // response side back-pressure
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= !rsp_idle_en || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // cut at the first zero byte and to CALL_CHARS bytes
  function automatic logic [63:0] trim_call(logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < CALL_CHARS && i < 8; i++) begin
      if (x[8*i +: 8] == 8'h00) break;
      r[8*i +: 8] = x[8*i +: 8];
    end
    return r;
  endfunction

  function automatic int find_route(logic [63:0] d);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (route_valid[i] && route_dest[i] == d) return i;
    end
    return -1;
  endfunction

  // update the model with one request and return the response it gives
  function automatic mrt_pkg::rsp_t apply_route_op(mrt_pkg::req_t r);
    mrt_pkg::rsp_t a;
    logic [63:0]   dest;
    logic [63:0]   via;
    logic [63:0]   me;
    int            s;
    bit            ok;
    a    = '0;
    dest = trim_call(r.dest_call);
    via  = trim_call(r.via_call);
    me   = trim_call(node_call);
    case (r.func)
      mrt_pkg::FUNC_LOOKUP: begin
        s = find_route(dest);
        if (dest != '0 && s >= 0) begin
          a.found    = 1'b1;
          a.via_out  = route_via[s];
          a.hops_out = route_hops[s];
        end
      end
      mrt_pkg::FUNC_LEARN: begin
        ok = dest != '0 && via != '0 && dest != me &&
             !(via == dest && r.hop_count != 8'd0) && via != me && r.via_available;
        if (ok) begin
          s = find_route(dest);
          if (s < 0) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (!route_valid[i]) begin
                s = i;
                break;
              end
            end
            // table full: oldest stamp goes, lowest slot on ties
            if (s < 0) begin
              s = 0;
              for (int i = 1; i < TABLE_DEPTH; i++) begin
                if (route_stamp[i] < route_stamp[s]) s = i;
              end
              a.evicted = 1'b1;
            end
            route_valid[s]    = 1'b1;
            route_dest[s]     = dest;
            route_via[s]      = via;
            route_hops[s]     = r.hop_count;
            route_stamp[s]    = r.now_time;
            a.table_changed   = 1'b1;
            a.new_destination = 1'b1;
          end else if (r.hop_count < route_hops[s]) begin
            route_via[s]    = via;
            route_hops[s]   = r.hop_count;
            route_stamp[s]  = r.now_time;
            a.table_changed = 1'b1;
          end else if (route_via[s] == via) begin
            route_stamp[s] = r.now_time;
          end
        end
      end
      mrt_pkg::FUNC_REMOVE: begin
        if (dest != '0) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (route_valid[i] && route_dest[i] == dest && route_via[i] == dest) begin
              route_valid[i]  = 1'b0;
              a.found         = 1'b1;
              a.table_changed = 1'b1;
              break;
            end
          end
        end
      end
      default: begin
        if (dest != '0) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (route_valid[i] && route_dest[i] == dest && route_via[i] == via) begin
              a.found = 1'b1;
              break;
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  // pack a string, first character in the low byte
  function automatic logic [63:0] pack_call(string s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // sometimes fill the bytes past the terminating zero with junk
  function automatic logic [63:0] garble_call(logic [63:0] x);
    logic [63:0] r;
    bit          seen;
    r    = x;
    seen = 1'b0;
    if ($urandom_range(3) == 0) begin
      for (int b = 0; b < 8; b++) begin
        if (seen) r[8*b +: 8] = 8'($urandom);
        else if (x[8*b +: 8] == 8'h00) seen = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic mrt_pkg::req_t mk_req(mrt_pkg::func_e f, logic [63:0] d,
                                           logic [63:0] v, logic [7:0] h,
                                           logic av, logic [31:0] t);
    mrt_pkg::req_t r;
    r.func          = f;
    r.dest_call     = d;
    r.via_call      = v;
    r.hop_count     = h;
    r.via_available = av;
    r.now_time      = t;
    return r;
  endfunction

  // random request, mostly built from the call pool and the current table
  function automatic mrt_pkg::req_t random_route_req();
    mrt_pkg::req_t r;
    int unsigned   pick;
    int unsigned   sub;
    int unsigned   slot;
    int unsigned   tp;
    logic [63:0]   d;
    logic [63:0]   v;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    slot = $urandom_range(TABLE_DEPTH - 1);
    d    = garble_call(call_pool[$urandom_range(POOL_SIZE - 1)]);
    v    = garble_call(call_pool[$urandom_range(POOL_SIZE - 1)]);
    stamp_now += 32'($urandom_range(2));
    tp = $urandom_range(99);
    r.now_time      = (tp < 3) ? 32'($urandom) : (tp == 3) ? 32'h0 :
                      (tp == 4) ? 32'hFFFF_FFFF : stamp_now;
    r.via_available = ($urandom_range(99) < 90);
    r.hop_count     = (sub < 70) ? 8'($urandom_range(7)) : 8'($urandom);
    if (pick < 5) begin
      // noise over the full field ranges
      r.func          = mrt_pkg::func_e'(2'($urandom_range(3)));
      d               = {$urandom, $urandom};
      v               = {$urandom, $urandom};
      r.hop_count     = 8'($urandom);
      r.via_available = 1'($urandom);
      r.now_time      = 32'($urandom);
    end else if (pick < 50) begin
      r.func = mrt_pkg::FUNC_LEARN;
      if (sub < 20) begin
        v           = garble_call(trim_call(d));
        r.hop_count = (sub < 18) ? 8'd0 : 8'($urandom_range(1, 255));
      end else if (sub < 24) begin
        v = node_call;
      end else if (sub < 27) begin
        v = '0;
      end else if (sub < 30) begin
        d = node_call;
      end
    end else if (pick < 70) begin
      r.func = mrt_pkg::FUNC_LOOKUP;
      if (route_valid[slot] && $urandom_range(1)) d = garble_call(route_dest[slot]);
    end else if (pick < 85) begin
      r.func = mrt_pkg::FUNC_CHECK;
      if (route_valid[slot] && $urandom_range(1)) begin
        d = garble_call(route_dest[slot]);
        if ($urandom_range(1)) v = garble_call(route_via[slot]);
      end
    end else begin
      r.func = mrt_pkg::FUNC_REMOVE;
      if (route_valid[slot] && $urandom_range(1)) d = garble_call(route_dest[slot]);
    end
    r.dest_call = d;
    r.via_call  = v;
    return r;
  endfunction

  // one request transfer, prediction made at the transfer
  task automatic send_route_req(input mrt_pkg::req_t r);
    while (req_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsp_q.insert(expected_rsp_q.size(), apply_route_op(r));
  endtask

  task automatic end_burst();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // register write once all responses are back
  task automatic write_own_call(input logic [63:0] value);
    end_burst();
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    node_call = value;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // response checker
  always @(posedge clk_i) begin : rsp_check
    mrt_pkg::rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected response transfer: %h", rsp_if.data);
      end else begin
        want = expected_rsp_q.pop_front();
        compare_field("found", 64'(rsp_if.data.found), 64'(want.found));
        compare_field("via_out", rsp_if.data.via_out, want.via_out);
        compare_field("hops_out", 64'(rsp_if.data.hops_out), 64'(want.hops_out));
        compare_field("table_changed", 64'(rsp_if.data.table_changed),
                      64'(want.table_changed));
        compare_field("new_destination", 64'(rsp_if.data.new_destination),
                      64'(want.new_destination));
        compare_field("evicted", 64'(rsp_if.data.evicted), 64'(want.evicted));
      end
    end
  end

  // queries on a table that is still empty
  task automatic test_empty_table();
    send_route_req(mk_req(mrt_pkg::FUNC_LOOKUP, '0, '0, 8'd0, 1'b0, 32'd0));
    send_route_req(mk_req(mrt_pkg::FUNC_LOOKUP, pack_call("ALPHA"), '0, 8'd0, 1'b0,
                          32'd1));
    send_route_req(mk_req(mrt_pkg::FUNC_CHECK, pack_call("ALPHA"), pack_call("BRAVO"),
                          8'd0, 1'b1, 32'd2));
    send_route_req(mk_req(mrt_pkg::FUNC_REMOVE, pack_call("ALPHA"), '0, 8'd0, 1'b0,
                          32'd3));
  endtask

  // learn rejections, insert, replace, refresh and no-op
  task automatic test_learn_rules();
    logic [63:0] home;
    home = pack_call("HOME");
    write_own_call(home);
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, '0, pack_call("BRAVO"), 8'd1, 1'b1,
                          32'd10));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), '0, 8'd1, 1'b1,
                          32'd11));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, home | {8'h77, 56'h0}, pack_call("BRAVO"),
                          8'd1, 1'b1, 32'd12));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), pack_call("ALPHA"),
                          8'd3, 1'b1, 32'd13));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), home, 8'd1, 1'b1,
                          32'd14));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), pack_call("BRAVO"),
                          8'd1, 1'b0, 32'd15));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), pack_call("BRAVO"),
                          8'd5, 1'b1, 32'd100));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), pack_call("CHARLIE"),
                          8'd3, 1'b1, 32'd101));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), pack_call("CHARLIE"),
                          8'd3, 1'b1, 32'hFFFF_FFFF));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ALPHA"), pack_call("BRAVO"),
                          8'd9, 1'b1, 32'd102));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("DELTA"), pack_call("DELTA"),
                          8'd0, 1'b1, 32'd103));
    send_route_req(mk_req(mrt_pkg::FUNC_LEARN, pack_call("ECHO"), pack_call("BRAVO"),
                          8'd255, 1'b1, 32'd0));
  endtask

  // lookup and check-pair hits and misses, junk past the terminator
  task automatic test_queries();
    send_route_req(mk_req(mrt_pkg::FUNC_LOOKUP, pack_call("ALPHA"), '0, 8'd0, 1'b0,
                          32'd0));
    send_route_req(mk_req(mrt_pkg::FUNC_LOOKUP, pack_call("ALPHA") | {8'hC3, 56'h0}, '1,
                          8'hFF, 1'b1, 32'hFFFF_FFFF));
    send_route_req(mk_req(mrt_pkg::FUNC_LOOKUP, pack_call("ECHO"), '0, 8'd0, 1'b0,
                          32'd0));
    send_route_req(mk_req(mrt_pkg::FUNC_CHECK, pack_call("ALPHA"), pack_call("CHARLIE"),
                          8'd0, 1'b0, 32'd0));
    send_route_req(mk_req(mrt_pkg::FUNC_CHECK, pack_call("ALPHA"), pack_call("BRAVO"),
                          8'd0, 1'b0, 32'd0));
    send_route_req(mk_req(mrt_pkg::FUNC_CHECK, '0, '0, 8'd0, 1'b0, 32'd0));
  endtask

  // remove only deletes self-via routes
  task automatic test_remove_direct();
    send_route_req(mk_req(mrt_pkg::FUNC_REMOVE, pack_call("ALPHA"), '0, 8'd0, 1'b0,
                          32'd0));
    send_route_req(mk_req(mrt_pkg::FUNC_REMOVE, pack_call("DELTA"), '0, 8'd0, 1'b0,
                          32'd0));
    send_route_req(mk_req(mrt_pkg::FUNC_REMOVE, pack_call("DELTA"), '0, 8'd0, 1'b0,
                          32'd0));
  endtask

  // random traffic under one own_call setting
  task automatic test_random_routes(input logic [63:0] own, input int count,
                                    input bit idle);
    write_own_call(own);
    req_idle_en = idle;
    rsp_idle_en = idle;
    repeat (count) send_route_req(random_route_req());
  endtask

  // main sequence
  initial begin
    logic [63:0] c;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      c = '0;
      for (int b = 0; b <= k % 8; b++) c[8*b +: 8] = 8'($urandom_range(1, 255));
      call_pool[k] = c;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_learn_rules();
    test_queries();
    test_remove_direct();
    test_random_routes('0, PHASE_ITEMS, 1'b1);
    test_random_routes(call_pool[0], PHASE_ITEMS, 1'b1);
    test_random_routes('1, PHASE_ITEMS, 1'b1);
    test_random_routes(call_pool[1] | {8'h5A, 56'h0}, PHASE_ITEMS, 1'b1);
    test_random_routes({$urandom, $urandom}, PHASE_ITEMS, 1'b1);
    test_random_routes(call_pool[2], PHASE_ITEMS, 1'b0);

    // drain and let the block settle
    end_burst();
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (OP_LATENCY + 8) @(posedge clk_i);
    if (error_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mrt_pkg.sv
rtl/mrt_stream_if.sv
rtl/mrt_ram.sv
rtl/mrt_ctrl.sv
rtl/mrt_dpath.sv
rtl/mesh_route_table.sv
verif/testbench.sv
